>>> rtl/mlpfp_pkg.sv
// Package for the dense-layer forward pass: sizes, item structs, command codes,
// controller-to-datapath command and status structs, and size helpers.
// No dependencies.
package mlpfp_pkg;

    localparam int MAX_LAYERS  = 4;
    localparam int MAX_WIDTH   = 16;
    localparam int VALUE_BITS  = 16;
    localparam int FRAC_BITS   = 8;

    localparam int IDX_BITS    = $clog2(MAX_WIDTH);
    localparam int SIZE_BITS   = IDX_BITS + 1;
    localparam int LAYER_BITS  = $clog2(MAX_LAYERS);
    localparam int MAT_BITS    = $clog2(MAX_LAYERS - 1);
    localparam int LCNT_BITS   = 3;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 5;
    localparam int W_DEPTH     = (MAX_LAYERS - 1) * MAX_WIDTH * MAX_WIDTH;
    localparam int WADDR_BITS  = MAT_BITS + 2 * IDX_BITS;
    localparam int PROD_BITS   = 2 * VALUE_BITS;
    localparam int TERM_BITS   = PROD_BITS - FRAC_BITS;
    localparam int ACC_BITS    = TERM_BITS + IDX_BITS;

    localparam logic [1:0] CMD_WEIGHT = 2'd0;
    localparam logic [1:0] CMD_ELEM   = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LAYER_COUNT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SIZE_BASE   = 3'd1;

    typedef struct packed {
        logic [1:0]                   cmd;
        logic [1:0]                   layer_sel;
        logic [3:0]                   neuron_sel;
        logic [3:0]                   weight_sel;
        logic [3:0]                   element_sel;
        logic signed [VALUE_BITS-1:0] value;
    } s_item_t;

    typedef struct packed {
        logic [3:0]                   out_index;
        logic signed [VALUE_BITS-1:0] out_value;
        logic                         last;
    } m_item_t;

    typedef struct packed {
        logic                  valid;
        logic                  first;
        logic                  last;
        logic                  src_front;
        logic                  src_bank;
        logic                  dst_bank;
        logic [MAT_BITS-1:0]   mat;
        logic [IDX_BITS-1:0]   row;
        logic [IDX_BITS-1:0]   col;
    } mac_cmd_t;

    typedef struct packed {
        logic                valid;
        logic                bank;
        logic                last;
        logic [IDX_BITS-1:0] index;
    } emit_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_free;
    } dp_status_t;

    function automatic logic [IDX_BITS-1:0] size_last(input logic [SIZE_BITS-1:0] s);
        logic [SIZE_BITS-1:0] m;
        begin
            m = s;
            if (s == '0) begin
                m = SIZE_BITS'(1);
            end else if (s > SIZE_BITS'(MAX_WIDTH)) begin
                m = SIZE_BITS'(MAX_WIDTH);
            end
            m = m - SIZE_BITS'(1);
            return m[IDX_BITS-1:0];
        end
    endfunction

    function automatic logic [LAYER_BITS-1:0] layers_last(input logic [LCNT_BITS-1:0] n);
        logic [LCNT_BITS-1:0] m;
        begin
            m = n;
            if (n < LCNT_BITS'(2)) begin
                m = LCNT_BITS'(2);
            end else if (n > LCNT_BITS'(MAX_LAYERS)) begin
                m = LCNT_BITS'(MAX_LAYERS);
            end
            m = m - LCNT_BITS'(1);
            return m[LAYER_BITS-1:0];
        end
    endfunction

endpackage

>>> rtl/mlpfp_ctrl.sv
// Controller: configuration registers and the run sequencer over layers, rows
// and columns, plus result emission. Depends on mlpfp_pkg.
module mlpfp_ctrl
    import mlpfp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     run_start,
    output logic                     s_ready,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  dp_status_t               status,
    output mac_cmd_t                 mac_cmd,
    output emit_cmd_t                emit_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [LAYER_BITS-1:0]   layer_reg;
    logic [LAYER_BITS-1:0]   last_layer_reg;
    logic [IDX_BITS-1:0]     row_reg;
    logic [IDX_BITS-1:0]     col_reg;
    logic [LCNT_BITS-1:0]    layer_count_reg;
    logic [SIZE_BITS-1:0]    size_reg [0:MAX_LAYERS-1];

    logic [LAYER_BITS-1:0]   prev_layer;
    logic [IDX_BITS-1:0]     prev_last;
    logic [IDX_BITS-1:0]     cur_last;
    logic [CFG_IDX_BITS-1:0] size_sel;

    assign cfg_ready  = 1'b1;
    assign s_ready    = (state_reg == ST_IDLE);
    assign prev_layer = layer_reg - LAYER_BITS'(1);
    assign prev_last  = size_last(size_reg[prev_layer]);
    assign cur_last   = size_last(size_reg[layer_reg]);
    assign size_sel   = cfg_index - CFG_SIZE_BASE;

    always_comb begin
        mac_cmd.valid     = (state_reg == ST_MAC);
        mac_cmd.first     = (col_reg == '0);
        mac_cmd.last      = (col_reg == prev_last);
        mac_cmd.src_front = (layer_reg == LAYER_BITS'(1));
        mac_cmd.src_bank  = layer_reg[0];
        mac_cmd.dst_bank  = ~layer_reg[0];
        mac_cmd.mat       = prev_layer[MAT_BITS-1:0];
        mac_cmd.row       = row_reg;
        mac_cmd.col       = col_reg;
        emit_cmd.valid    = (state_reg == ST_EMIT) && status.out_free;
        emit_cmd.bank     = ~layer_reg[0];
        emit_cmd.last     = (row_reg == cur_last);
        emit_cmd.index    = row_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            layer_reg       <= '0;
            last_layer_reg  <= '0;
            row_reg         <= '0;
            col_reg         <= '0;
            layer_count_reg <= LCNT_BITS'(2);
            for (int i = 0; i < MAX_LAYERS; i++) begin
                size_reg[i] <= SIZE_BITS'(MAX_WIDTH);
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_LAYER_COUNT) begin
                    layer_count_reg <= cfg_data[LCNT_BITS-1:0];
                end else if (cfg_index >= CFG_SIZE_BASE &&
                             size_sel < CFG_IDX_BITS'(MAX_LAYERS)) begin
                    size_reg[size_sel[LAYER_BITS-1:0]] <= cfg_data[SIZE_BITS-1:0];
                end
            end
            case (state_reg)
                ST_IDLE: begin
                    if (run_start) begin
                        layer_reg      <= LAYER_BITS'(1);
                        last_layer_reg <= layers_last(layer_count_reg);
                        row_reg        <= '0;
                        col_reg        <= '0;
                        state_reg      <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (col_reg == prev_last) begin
                        col_reg <= '0;
                        if (row_reg == cur_last) begin
                            row_reg   <= '0;
                            state_reg <= ST_DRAIN;
                        end else begin
                            row_reg <= row_reg + IDX_BITS'(1);
                        end
                    end else begin
                        col_reg <= col_reg + IDX_BITS'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!status.busy) begin
                        if (layer_reg == last_layer_reg) begin
                            state_reg <= ST_EMIT;
                        end else begin
                            layer_reg <= layer_reg + LAYER_BITS'(1);
                            state_reg <= ST_MAC;
                        end
                    end
                end
                ST_EMIT: begin
                    if (status.out_free) begin
                        if (row_reg == cur_last) begin
                            row_reg   <= '0;
                            layer_reg <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            row_reg <= row_reg + IDX_BITS'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/mlpfp_datapath.sv
// Datapath: weight store, activation buffers, multiply-accumulate pipeline,
// saturation and the result register. Depends on mlpfp_pkg.
module mlpfp_datapath
    import mlpfp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load_fire,
    input  s_item_t     s_data,
    input  mac_cmd_t    mac_cmd,
    input  emit_cmd_t   emit_cmd,
    output dp_status_t  status,
    output logic        m_valid,
    input  logic        m_ready,
    output m_item_t     m_data
);

    logic signed [VALUE_BITS-1:0] wmem      [0:W_DEPTH-1];
    logic signed [VALUE_BITS-1:0] front_mem [0:MAX_WIDTH-1];
    logic signed [VALUE_BITS-1:0] back_mem  [0:1][0:MAX_WIDTH-1];

    logic signed [VALUE_BITS-1:0] w_rd_reg;
    logic signed [VALUE_BITS-1:0] a_rd_reg;
    logic signed [PROD_BITS-1:0]  prod_reg;
    logic signed [ACC_BITS-1:0]   acc_reg;
    logic signed [ACC_BITS-1:0]   acc_next;

    logic                s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                s1_first_reg, s2_first_reg;
    logic                s1_last_reg, s2_last_reg, s3_last_reg;
    logic                s1_dst_reg, s2_dst_reg, s3_dst_reg;
    logic [IDX_BITS-1:0] s1_row_reg, s2_row_reg, s3_row_reg;

    logic                m_valid_reg;
    m_item_t             m_data_reg;

    logic [WADDR_BITS-1:0]        waddr_wr;
    logic [WADDR_BITS-1:0]        waddr_rd;
    logic                         back_bank;
    logic [IDX_BITS-1:0]          back_idx;
    logic signed [VALUE_BITS-1:0] back_rd;
    logic signed [TERM_BITS-1:0]  term;

    function automatic logic signed [VALUE_BITS-1:0] sat_value(
        input logic signed [ACC_BITS-1:0] v);
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        begin
            hi = ACC_BITS'((64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1);
            lo = -hi - ACC_BITS'(1);
            if (v > hi) begin
                return hi[VALUE_BITS-1:0];
            end else if (v < lo) begin
                return lo[VALUE_BITS-1:0];
            end
            return v[VALUE_BITS-1:0];
        end
    endfunction

    assign waddr_wr  = {s_data.layer_sel[MAT_BITS-1:0], s_data.neuron_sel, s_data.weight_sel};
    assign waddr_rd  = {mac_cmd.mat, mac_cmd.row, mac_cmd.col};
    assign back_bank = emit_cmd.valid ? emit_cmd.bank : mac_cmd.src_bank;
    assign back_idx  = emit_cmd.valid ? emit_cmd.index : mac_cmd.col;
    assign back_rd   = back_mem[back_bank][back_idx];
    assign term      = prod_reg[PROD_BITS-1:FRAC_BITS];
    assign acc_next  = (s2_first_reg ? '0 : acc_reg) + ACC_BITS'(term);

    assign status.busy     = s1_valid_reg | s2_valid_reg | s3_valid_reg;
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

    always_ff @(posedge aclk) begin
        if (load_fire && s_data.cmd == CMD_WEIGHT &&
            s_data.layer_sel < 2'(MAX_LAYERS - 1)) begin
            wmem[waddr_wr] <= s_data.value;
        end
        w_rd_reg <= wmem[waddr_rd];
    end

    always_ff @(posedge aclk) begin
        if (load_fire && s_data.cmd == CMD_ELEM) begin
            front_mem[s_data.element_sel] <= s_data.value;
        end else if (emit_cmd.valid) begin
            front_mem[emit_cmd.index] <= back_rd;
        end
        if (s3_valid_reg && s3_last_reg) begin
            back_mem[s3_dst_reg][s3_row_reg] <= sat_value(acc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        a_rd_reg     <= mac_cmd.src_front ? front_mem[mac_cmd.col] : back_rd;
        s1_first_reg <= mac_cmd.first;
        s1_last_reg  <= mac_cmd.last;
        s1_dst_reg   <= mac_cmd.dst_bank;
        s1_row_reg   <= mac_cmd.row;
        prod_reg     <= a_rd_reg * w_rd_reg;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_dst_reg   <= s1_dst_reg;
        s2_row_reg   <= s1_row_reg;
        if (s2_valid_reg) begin
            acc_reg <= acc_next;
        end
        s3_last_reg  <= s2_last_reg;
        s3_dst_reg   <= s2_dst_reg;
        s3_row_reg   <= s2_row_reg;
        if (emit_cmd.valid) begin
            m_data_reg.out_index <= emit_cmd.index;
            m_data_reg.out_value <= back_rd;
            m_data_reg.last      <= emit_cmd.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= mac_cmd.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (emit_cmd.valid) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/mlp_forward_pass_top.sv
// Load items are taken while the controller is idle. A run issues, per layer,
// size(k-1)*size(k) products to the single multiply-accumulate pipeline, then
// drains it, then emits one final-layer result per cycle while the output is
// taken; the first result follows once the last product has drained.
// Synchronous active-low reset clears control state and sets the registers to
// two layers of width 16; weight and activation stores are not cleared.
module mlp_forward_pass_top
    import mlpfp_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  s_item_t                  s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output m_item_t                  m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic       in_fire;
    logic       run_start;
    mac_cmd_t   mac_cmd;
    emit_cmd_t  emit_cmd;
    dp_status_t dp_status;

    assign in_fire   = s_valid && s_ready;
    assign run_start = in_fire && (s_data.cmd == CMD_RUN);

    mlpfp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .run_start (run_start),
        .s_ready   (s_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (dp_status),
        .mac_cmd   (mac_cmd),
        .emit_cmd  (emit_cmd)
    );

    mlpfp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load_fire (in_fire),
        .s_data    (s_data),
        .mac_cmd   (mac_cmd),
        .emit_cmd  (emit_cmd),
        .status    (dp_status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

`ifndef SYNTHESIS
    a_idle_when_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !dp_status.busy && !mac_cmd.valid)
        else $error("input taken while products in flight");

    a_emit_after_drain : assert property (@(posedge aclk) disable iff (!aresetn)
        emit_cmd.valid |-> !dp_status.busy && !mac_cmd.valid)
        else $error("result emitted before layer drained");

    a_emit_fills_out : assert property (@(posedge aclk) disable iff (!aresetn)
        emit_cmd.valid |=> m_valid && m_data.out_index == $past(emit_cmd.index))
        else $error("emitted result not presented");
`endif

endmodule
